// File: src/lkps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkps_pkg
// Shared widths, stage counts, divider result type and Q16.16 saturation.
// ----------------------------------------------------------------------------
package lkps_pkg;

   localparam int GRAD_W      = 31;
   localparam int SIGNED_W    = 32;
   localparam int EIG_W       = 33;
   localparam int FLOW_W      = 32;
   localparam int PROD_W      = 64;
   localparam int RAD_W       = 63;
   localparam int ROOT_W      = 32;
   localparam int SQRT_REM_W  = 36;
   localparam int SQRT_STAGES = 32;
   localparam int QUO_W       = 32;
   localparam int FRAC_W      = 16;
   localparam int DIV_STAGES  = QUO_W + 1;
   localparam int PIPE_DEPTH  = 3 + DIV_STAGES + 1;

   localparam logic [GRAD_W-1:0] THRESHOLD_RESET = 31'd10737;
   localparam logic [FLOW_W-1:0] FLOW_MAX = 32'h7FFF_FFFF;
   localparam logic [FLOW_W-1:0] FLOW_MIN = 32'h8000_0000;

   typedef struct packed {
      logic [QUO_W-1:0] mag;
      logic             neg;
      logic             ovf;
   } div_result_type;

   function automatic logic [FLOW_W-1:0] sat_q16(input div_result_type r);
      logic [FLOW_W-1:0] res;
      if (r.ovf) begin
         res = r.neg ? FLOW_MIN : FLOW_MAX;
      end else if (r.neg) begin
         res = (r.mag > FLOW_MIN) ? FLOW_MIN : (~r.mag + 1'b1);
      end else begin
         res = (r.mag > FLOW_MAX) ? FLOW_MAX : r.mag;
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// File: src/lkps_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkps_sqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
module lkps_sqrt import lkps_pkg::*; (
   input  wire logic              clock,
   input  wire logic              enable,
   input  wire logic [RAD_W-1:0]  radicand,
   output logic      [ROOT_W-1:0] root
);

   logic [SQRT_REM_W-1:0] rem_ff  [SQRT_STAGES];
   logic [ROOT_W-1:0]     root_ff [SQRT_STAGES];
   logic [RAD_W:0]        rad_ff  [SQRT_STAGES];

   for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
      logic [SQRT_REM_W-1:0] rem_prev;
      logic [ROOT_W-1:0]     root_prev;
      logic [RAD_W:0]        rad_prev;
      logic [SQRT_REM_W-1:0] rem_sh;
      logic [SQRT_REM_W-1:0] trial;
      logic                  ge;

      if (i == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = {1'b0, radicand};
      end else begin : g_next
         assign rem_prev  = rem_ff[i-1];
         assign root_prev = root_ff[i-1];
         assign rad_prev  = rad_ff[i-1];
      end

      assign rem_sh = {rem_prev[SQRT_REM_W-3:0], rad_prev[RAD_W-2*i -: 2]};
      assign trial  = {{(SQRT_REM_W-ROOT_W-2){1'b0}}, root_prev, 2'b01};
      assign ge     = (rem_sh >= trial);

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[i]  <= ge ? (rem_sh - trial) : rem_sh;
            root_ff[i] <= {root_prev[ROOT_W-2:0], ge};
            rad_ff[i]  <= rad_prev;
         end
      end
   end

   assign root = root_ff[SQRT_STAGES-1];

endmodule
`default_nettype wire

// File: src/lkps_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkps_div
// Pipelined signed divide, trunc(num * 2^16 / den), one quotient bit per
// stage after a sign/overflow prep stage.
// ----------------------------------------------------------------------------
module lkps_div import lkps_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     enable,
   input  wire logic signed [PROD_W-1:0] num,
   input  wire logic signed [PROD_W-1:0] den,
   output div_result_type                result
);

   logic [PROD_W-1:0] n_abs;
   logic [PROD_W-1:0] d_abs;

   logic [PROD_W-1:0] prem_ff;
   logic [FRAC_W-1:0] plo_ff;
   logic [PROD_W-1:0] pden_ff;
   logic              pneg_ff;
   logic              povf_ff;

   logic [PROD_W-1:0] rem_ff [QUO_W];
   logic [QUO_W-1:0]  quo_ff [QUO_W];
   logic [FRAC_W-1:0] lo_ff  [QUO_W];
   logic [PROD_W-1:0] den_ff [QUO_W];
   logic              neg_ff [QUO_W];
   logic              ovf_ff [QUO_W];

   assign n_abs = num[PROD_W-1] ? (~num + 1'b1) : num;
   assign d_abs = den[PROD_W-1] ? (~den + 1'b1) : den;

   always_ff @(posedge clock) begin
      if (enable) begin
         prem_ff <= {{FRAC_W{1'b0}}, n_abs[PROD_W-1:FRAC_W]};
         plo_ff  <= n_abs[FRAC_W-1:0];
         pden_ff <= d_abs;
         pneg_ff <= num[PROD_W-1] ^ den[PROD_W-1];
         povf_ff <= ({{FRAC_W{1'b0}}, n_abs} >= {d_abs, {FRAC_W{1'b0}}});
      end
   end

   for (genvar j = 0; j < QUO_W; j++) begin : g_stage
      logic [PROD_W-1:0] rem_prev;
      logic [QUO_W-1:0]  quo_prev;
      logic [FRAC_W-1:0] lo_prev;
      logic [PROD_W-1:0] den_prev;
      logic              neg_prev;
      logic              ovf_prev;
      logic              nbit;
      logic [PROD_W-1:0] rem_sh;
      logic              ge;

      if (j == 0) begin : g_first
         assign rem_prev = prem_ff;
         assign quo_prev = '0;
         assign lo_prev  = plo_ff;
         assign den_prev = pden_ff;
         assign neg_prev = pneg_ff;
         assign ovf_prev = povf_ff;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign quo_prev = quo_ff[j-1];
         assign lo_prev  = lo_ff[j-1];
         assign den_prev = den_ff[j-1];
         assign neg_prev = neg_ff[j-1];
         assign ovf_prev = ovf_ff[j-1];
      end

      if (j < FRAC_W) begin : g_lo
         assign nbit = lo_prev[FRAC_W-1-j];
      end else begin : g_zero
         assign nbit = 1'b0;
      end

      assign rem_sh = {rem_prev[PROD_W-2:0], nbit};
      assign ge     = (rem_sh >= den_prev);

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[j] <= ge ? (rem_sh - den_prev) : rem_sh;
            quo_ff[j] <= {quo_prev[QUO_W-2:0], ge};
            lo_ff[j]  <= lo_prev;
            den_ff[j] <= den_prev;
            neg_ff[j] <= neg_prev;
            ovf_ff[j] <= ovf_prev;
         end
      end
   end

   assign result.mag = quo_ff[QUO_W-1];
   assign result.neg = neg_ff[QUO_W-1];
   assign result.ovf = ovf_ff[QUO_W-1];

endmodule
`default_nettype wire

// File: src/lucas_kanade_pixel_solve.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lucas_kanade_pixel_solve
// Per-pixel 2x2 structure tensor solve: eigenvalues and Q16.16 flow.
// ----------------------------------------------------------------------------
// Fully pipelined: one pixel per cycle while the output is not stalled. The
// pipeline is three multiply/add stages, then the two 33-stage dividers (u
// and v; a sign/overflow stage and 32 quotient stages), then one output
// stage. The 32-stage square root and the eigenvalue add stage run beside
// the dividers. A stalled output freezes the whole pipeline; nothing is
// dropped. The threshold register is written through the csr_ port and is
// always ready.
// ----------------------------------------------------------------------------
module lucas_kanade_pixel_solve import lkps_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic        [GRAD_W-1:0]   req_grad_xx,
   input  wire logic        [GRAD_W-1:0]   req_grad_yy,
   input  wire logic signed [SIGNED_W-1:0] req_grad_xy,
   input  wire logic signed [SIGNED_W-1:0] req_time_x,
   input  wire logic signed [SIGNED_W-1:0] req_time_y,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic signed [EIG_W-1:0]         rsp_eig_large,
   output logic signed [EIG_W-1:0]         rsp_eig_small,
   output logic signed [FLOW_W-1:0]        rsp_flow_u,
   output logic signed [FLOW_W-1:0]        rsp_flow_v,
   output logic                            rsp_solved,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic        [GRAD_W-1:0]   csr_min_eig_threshold
);

   logic                   pipe_en;
   logic [PIPE_DEPTH-1:0]  valid_ff;
   logic [PIPE_DEPTH-1:0]  valid_in;
   logic [GRAD_W-1:0]      thr_ff;

   // stage 1
   logic        [GRAD_W-1:0]   sxx1_ff, syy1_ff;
   logic signed [SIGNED_W-1:0] sxy1_ff, bx1_ff, by1_ff, dd1_ff;
   // stage 2
   logic signed [PROD_W-1:0]   du2_ff, xy2_ff, xxyy2_ff;
   logic signed [PROD_W-1:0]   ybx2_ff, xyby2_ff, xby2_ff, xybx2_ff;
   logic        [GRAD_W-1:0]   half2_ff;
   logic        [GRAD_W:0]     tr_in;
   // stage 3
   logic        [PROD_W-1:0]   q3_in;
   logic        [RAD_W-1:0]    q3_ff;
   logic signed [PROD_W-1:0]   det3_ff, nu3_ff, nv3_ff;
   logic        [GRAD_W-1:0]   half3_ff;
   // carried beside the square root
   logic        [GRAD_W-1:0]   half_ff  [SQRT_STAGES];
   logic                       detnz_ff [SQRT_STAGES];
   // stage 36
   logic        [ROOT_W-1:0]   root;
   logic signed [EIG_W-1:0]    el36_ff, es36_ff;
   logic                       detnz36_ff;
   // unit results and stage 37
   div_result_type             res_u, res_v;
   logic                       solved_in;
   logic signed [EIG_W-1:0]    el_ff, es_ff;
   logic signed [FLOW_W-1:0]   fu_ff, fv_ff;
   logic                       solved_ff;

   assign pipe_en   = !valid_ff[PIPE_DEPTH-1] || rsp_ready;
   assign req_ready = pipe_en;
   assign csr_ready = 1'b1;

   assign valid_in = {valid_ff[PIPE_DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         thr_ff   <= THRESHOLD_RESET;
      end else begin
         if (pipe_en) begin
            valid_ff <= valid_in;
         end
         if (csr_valid) begin
            thr_ff <= csr_min_eig_threshold;
         end
      end
   end

   assign tr_in = {1'b0, sxx1_ff} + {1'b0, syy1_ff};
   assign q3_in = (du2_ff >>> 2) + xy2_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sxx1_ff <= req_grad_xx;
         syy1_ff <= req_grad_yy;
         sxy1_ff <= req_grad_xy;
         bx1_ff  <= req_time_x;
         by1_ff  <= req_time_y;
         dd1_ff  <= $signed({1'b0, req_grad_xx}) - $signed({1'b0, req_grad_yy});

         du2_ff   <= dd1_ff * dd1_ff;
         xy2_ff   <= sxy1_ff * sxy1_ff;
         xxyy2_ff <= $signed({1'b0, sxx1_ff}) * $signed({1'b0, syy1_ff});
         ybx2_ff  <= $signed({1'b0, syy1_ff}) * bx1_ff;
         xyby2_ff <= sxy1_ff * by1_ff;
         xby2_ff  <= $signed({1'b0, sxx1_ff}) * by1_ff;
         xybx2_ff <= sxy1_ff * bx1_ff;
         half2_ff <= tr_in[GRAD_W:1];

         q3_ff    <= q3_in[RAD_W-1:0];
         det3_ff  <= xxyy2_ff - xy2_ff;
         nu3_ff   <= ybx2_ff - xyby2_ff;
         nv3_ff   <= xby2_ff - xybx2_ff;
         half3_ff <= half2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         half_ff[0]  <= half3_ff;
         detnz_ff[0] <= (det3_ff != '0);
         for (int k = 1; k < SQRT_STAGES; k++) begin
            half_ff[k]  <= half_ff[k-1];
            detnz_ff[k] <= detnz_ff[k-1];
         end
      end
   end

   lkps_sqrt u_sqrt (
      .clock    (clock),
      .enable   (pipe_en),
      .radicand (q3_ff),
      .root     (root)
   );

   lkps_div u_div_u (
      .clock  (clock),
      .enable (pipe_en),
      .num    (nu3_ff),
      .den    (det3_ff),
      .result (res_u)
   );

   lkps_div u_div_v (
      .clock  (clock),
      .enable (pipe_en),
      .num    (nv3_ff),
      .den    (det3_ff),
      .result (res_v)
   );

   assign solved_in = ($signed(es36_ff) >= $signed({2'b00, thr_ff})) && detnz36_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         el36_ff    <= $signed({2'b00, half_ff[SQRT_STAGES-1]}) + $signed({1'b0, root});
         es36_ff    <= $signed({2'b00, half_ff[SQRT_STAGES-1]}) - $signed({1'b0, root});
         detnz36_ff <= detnz_ff[SQRT_STAGES-1];

         el_ff     <= el36_ff;
         es_ff     <= es36_ff;
         fu_ff     <= solved_in ? sat_q16(res_u) : '0;
         fv_ff     <= solved_in ? sat_q16(res_v) : '0;
         solved_ff <= solved_in;
      end
   end

   assign rsp_valid     = valid_ff[PIPE_DEPTH-1];
   assign rsp_eig_large = el_ff;
   assign rsp_eig_small = es_ff;
   assign rsp_flow_u    = fu_ff;
   assign rsp_flow_v    = fv_ff;
   assign rsp_solved    = solved_ff;

   a_unsolved_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_solved |-> rsp_flow_u == '0 && rsp_flow_v == '0)
      else $error("unsolved transaction with nonzero flow");

   a_eig_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_eig_large >= rsp_eig_small)
      else $error("eigenvalues out of order");

   a_solved_thr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_solved |-> rsp_eig_small >= $signed({2'b00, thr_ff}))
      else $error("solved transaction below threshold");

endmodule
`default_nettype wire

// File: bench/lucas_kanade_pixel_solve_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lucas_kanade_pixel_solve_tb
// Drives structure tensor pixels and threshold writes into the flow solver
// with random idle bursts on both sides, and checks every result transaction
// against an in-bench model of the eigenvalue, threshold test and Q16.16
// Cramer solve.
// ----------------------------------------------------------------------------
module lucas_kanade_pixel_solve_tb;
   import lkps_pkg::*;

   typedef struct {
      logic signed [EIG_W-1:0]  eig_large;
      logic signed [EIG_W-1:0]  eig_small;
      logic signed [FLOW_W-1:0] flow_u;
      logic signed [FLOW_W-1:0] flow_v;
      logic                     solved;
   } flow_result_type;

   class flow_scoreboard;
      flow_result_type pending[$];
      logic [GRAD_W-1:0] threshold;
      int mismatches;

      function new();
         threshold = THRESHOLD_RESET;
         mismatches = 0;
      endfunction

      function longint unsigned isqrt(longint unsigned n);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > n) b = b >> 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n = n - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function logic [FLOW_W-1:0] q16_divide(longint signed num,
                                             longint signed den);
         logic neg;
         longint unsigned n, d, q, r, mag;
         neg = (num < 0) != (den < 0);
         n = (num < 0) ? -num : num;
         d = (den < 0) ? -den : den;
         q = n / d;
         r = n % d;
         if (q >= 64'h10000) return neg ? FLOW_MIN : FLOW_MAX;
         mag = q << 16;
         for (int i = 15; i >= 0; i--) begin
            r = r << 1;
            if (r >= d) begin
               r = r - d;
               mag[i] = 1'b1;
            end
         end
         if (neg) return (mag > 64'h80000000) ? FLOW_MIN : FLOW_W'(-mag);
         return (mag > 64'h7FFFFFFF) ? FLOW_MAX : FLOW_W'(mag);
      endfunction

      function void note_pixel(logic [GRAD_W-1:0] gxx, logic [GRAD_W-1:0] gyy,
                               logic signed [SIGNED_W-1:0] gxy,
                               logic signed [SIGNED_W-1:0] tx,
                               logic signed [SIGNED_W-1:0] ty);
         longint signed sxx, syy, sxy, bx, by, dd, h, half, el, es, det;
         longint unsigned q;
         flow_result_type e;
         sxx = gxx; syy = gyy; sxy = gxy; bx = tx; by = ty;
         dd = sxx - syy;
         q = (longint'(dd * dd) >> 2) + longint'(sxy * sxy);
         h = isqrt(q);
         half = (sxx + syy) >>> 1;
         el = half + h;
         es = half - h;
         e.eig_large = el[EIG_W-1:0];
         e.eig_small = es[EIG_W-1:0];
         e.flow_u = '0;
         e.flow_v = '0;
         e.solved = 1'b0;
         if (es >= longint'(threshold)) begin
            det = sxx * syy - sxy * sxy;
            if (det != 0) begin
               e.flow_u = q16_divide(syy * bx - sxy * by, det);
               e.flow_v = q16_divide(sxx * by - sxy * bx, det);
               e.solved = 1'b1;
            end
         end
         pending.push_back(e);
      endfunction

      function void check_result(flow_result_type a);
         flow_result_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: unexpected result transaction");
            return;
         end
         e = pending.pop_front();
         if (a.eig_large !== e.eig_large || a.eig_small !== e.eig_small ||
             a.flow_u !== e.flow_u || a.flow_v !== e.flow_v ||
             a.solved !== e.solved) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: exp el=%0d es=%0d u=%0d v=%0d s=%0b",
                        e.eig_large, e.eig_small, e.flow_u, e.flow_v, e.solved,
                        " got el=%0d es=%0d u=%0d v=%0d s=%0b",
                        a.eig_large, a.eig_small, a.flow_u, a.flow_v, a.solved);
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_ready = 0, csr_valid = 0;
   logic req_ready, rsp_valid, csr_ready, rsp_solved;
   logic [GRAD_W-1:0] req_grad_xx = 0, req_grad_yy = 0, csr_min_eig_threshold = 0;
   logic signed [SIGNED_W-1:0] req_grad_xy = 0, req_time_x = 0, req_time_y = 0;
   logic signed [EIG_W-1:0] rsp_eig_large, rsp_eig_small;
   logic signed [FLOW_W-1:0] rsp_flow_u, rsp_flow_v;
   bit quiet = 0;
   flow_scoreboard board = new();

   lucas_kanade_pixel_solve DUT (.*);

   initial forever #5 clock = ~clock;

   initial begin
      #20_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // sample at rising edge
   always @(posedge clock) begin
      flow_result_type r;
      if (!reset && rsp_valid && rsp_ready) begin
         r.eig_large = rsp_eig_large;
         r.eig_small = rsp_eig_small;
         r.flow_u = rsp_flow_u;
         r.flow_v = rsp_flow_v;
         r.solved = rsp_solved;
         board.check_result(r);
      end
      if (!reset && req_valid && req_ready)
         board.note_pixel(req_grad_xx, req_grad_yy, req_grad_xy, req_time_x, req_time_y);
   end

   // receiver stalls
   initial begin
      int n;
      @(negedge clock);
      forever begin
         rsp_ready <= 1;
         n = $urandom_range(1, 30);
         repeat (n) @(negedge clock);
         if (!quiet && $urandom_range(0, 2) != 0) begin
            rsp_ready <= 0;
            n = $urandom_range(1, 11);
            repeat (n) @(negedge clock);
         end
      end
   end

   task automatic send_pixel(logic [GRAD_W-1:0] gxx, logic [GRAD_W-1:0] gyy,
                             logic [SIGNED_W-1:0] gxy, logic [SIGNED_W-1:0] tx,
                             logic [SIGNED_W-1:0] ty);
      int n;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         n = $urandom_range(1, 11);
         repeat (n) @(negedge clock);
      end
      req_valid <= 1;
      req_grad_xx <= gxx;
      req_grad_yy <= gyy;
      req_grad_xy <= gxy;
      req_time_x <= tx;
      req_time_y <= ty;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (PIPE_DEPTH + 5) @(negedge clock);
   endtask

   task automatic write_threshold(logic [GRAD_W-1:0] t);
      csr_valid <= 1;
      csr_min_eig_threshold <= t;
      do @(posedge clock); while (!csr_ready);
      board.threshold = t;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // random tensor, sometimes with equal diagonals or zero cross term, with random time terms
   task automatic send_random(int shift);
      logic [GRAD_W-1:0] a, b;
      logic [SIGNED_W-1:0] c;
      int m;
      m = $urandom_range(0, 9);
      a = GRAD_W'($urandom >> (1 + $urandom_range(0, shift)));
      b = GRAD_W'($urandom >> (1 + $urandom_range(0, shift)));
      c = $urandom;
      if (m < 6) c = $signed(c) >>> ($urandom_range(2, 31));
      else if (m == 6) c = 0;
      if (m == 7) b = a;
      send_pixel(a, b, c, $urandom >> $urandom_range(0, 31),
                 $urandom >> $urandom_range(0, 31));
   endtask

   localparam logic [GRAD_W-1:0] GMAX = 31'h7FFF_FFFF;

   initial begin
      repeat (6) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // directed: extremes, below threshold, singular, saturation
      send_pixel(0, 0, 0, 0, 0);
      send_pixel(GMAX, GMAX, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
      send_pixel(GMAX, GMAX, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
      send_pixel(GMAX, 0, 0, 5, 5);
      send_pixel(GMAX, GMAX, 0, 32'sh8000_0000, 32'sh7FFF_FFFF);
      send_pixel(31'd20000, 31'd20000, 0, 32'sh7FFF_FFFF, 32'sh8000_0000);
      send_pixel(31'd1 << 30, 31'd1 << 30, 32'sh2000_0000, 32'sh1234_5678, -32'sd99);
      send_pixel(31'd10737, 31'd10737, 0, -1, 1);
      send_pixel(31'd10738, 31'd10736, 0, -1, 1);
      send_pixel(GMAX, 1, 1, 32'sh4000_0000, -32'sh4000_0000);
      drain();
      write_threshold(0);
      send_pixel(100, 100, 100, 7, 9);           // singular
      send_pixel(0, 0, 0, 3, 3);
      send_pixel(31'd1000, 31'd1000, 32'sd999, 32'sh7FFF_FFFF, 32'sh8000_0000);
      send_pixel(5, 5, -32'sd5, 1, -1);
      for (int i = 0; i < 100; i++) send_random(30);
      drain();
      write_threshold(GMAX);
      send_pixel(GMAX, GMAX, 0, 1, 1);
      for (int i = 0; i < 40; i++) send_random(4);
      drain();
      write_threshold(GRAD_W'($urandom >> 8));
      for (int i = 0; i < 130; i++) send_random(12);
      drain();
      write_threshold(THRESHOLD_RESET);
      quiet = 1;
      for (int i = 0; i < 130; i++) send_random(12);
      drain();
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
